/* rtl/kla_pkg.sv */
// ----------------------------------------------------------------------------
// kla_pkg
// Shared types and constants of the keyframe lerp animator.
// ----------------------------------------------------------------------------
`default_nettype none

package kla_pkg;

   // word codes carried in req_tuser
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam int NCOMP  = 6;
   localparam int COMP_W = 32;
   localparam int FRAC_W = 16;

   typedef logic [NCOMP-1:0][COMP_W-1:0] pose_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TEND,
      ST_TLOOP,
      ST_SRD,
      ST_SCHK,
      ST_XRD,
      ST_XCAP,
      ST_DIV,
      ST_PRD0,
      ST_PRD1,
      ST_PCAP,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic do_append;
      logic do_clear;
      logic t_add;
      logic t_end;
      logic t_loop;
      logic srch_rd;
      logic srch_chk;
      logic div_step;
      logic pose_rd;
      logic pose_rd_hi;
      logic set_exact;
      logic cap_a;
      logic cap_b;
      logic mul;
      logic acc;
      logic out_load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       loop_wrap;
      logic       cnt_lt2;
      logic       found;
      logic       exact;
      logic       srch_last;
      logic       div_last;
      logic       comp_last;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/kla_ram.sv */
// ----------------------------------------------------------------------------
// kla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/kla_ctrl.sv */
// ----------------------------------------------------------------------------
// kla_ctrl
// Sequencer: steps one word through append or clear, or time update, search, divide and lerp.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire kla_pkg::stat_type stat,
   output kla_pkg::ctl_type       ctl
);
   import kla_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (stat.cmd == CMD_TICK) state_in = ST_TEND;
            else                      state_in = ST_DONE;
         end
         ST_TEND: begin
            priority if (stat.loop_wrap) state_in = ST_TLOOP;
            else if (stat.cnt_lt2)       state_in = ST_DONE;
            else                         state_in = ST_SRD;
         end
         ST_TLOOP: begin
            if (stat.cnt_lt2) state_in = ST_DONE;
            else              state_in = ST_SRD;
         end
         ST_SRD:   state_in = ST_SCHK;
         ST_SCHK: begin
            priority if (stat.found && stat.exact) state_in = ST_XRD;
            else if (stat.found)                   state_in = ST_DIV;
            else if (stat.srch_last)               state_in = ST_DONE;
            else                                   state_in = ST_SRD;
         end
         ST_XRD:   state_in = ST_XCAP;
         ST_XCAP:  state_in = ST_DONE;
         ST_DIV:   if (stat.div_last) state_in = ST_PRD0;
         ST_PRD0:  state_in = ST_PRD1;
         ST_PRD1:  state_in = ST_PCAP;
         ST_PCAP:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            if (stat.comp_last) state_in = ST_DONE;
            else                state_in = ST_MUL;
         end
         ST_DONE:  if (stat.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            ctl.load_item = req_tvalid;
         end
         ST_EXEC: begin
            ctl.do_append = (stat.cmd == CMD_APPEND);
            ctl.do_clear  = (stat.cmd == CMD_CLEAR);
            ctl.t_add     = (stat.cmd == CMD_TICK);
         end
         ST_TEND:  ctl.t_end = 1'b1;
         ST_TLOOP: ctl.t_loop = 1'b1;
         ST_SRD:   ctl.srch_rd = 1'b1;
         ST_SCHK:  ctl.srch_chk = 1'b1;
         ST_XRD: begin
            ctl.pose_rd    = 1'b1;
            ctl.pose_rd_hi = 1'b1;
         end
         ST_XCAP:  ctl.set_exact = 1'b1;
         ST_DIV:   ctl.div_step = 1'b1;
         ST_PRD0:  ctl.pose_rd = 1'b1;
         ST_PRD1: begin
            ctl.pose_rd    = 1'b1;
            ctl.pose_rd_hi = 1'b1;
            ctl.cap_a      = 1'b1;
         end
         ST_PCAP:  ctl.cap_b = 1'b1;
         ST_MUL:   ctl.mul = 1'b1;
         ST_ACC:   ctl.acc = 1'b1;
         ST_DONE:  ctl.out_load = stat.out_free;
         default:  ctl = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/kla_dp.sv */
// ----------------------------------------------------------------------------
// kla_dp
// Datapath: key tables, animation time, search, restoring divider,
// shared lerp multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_dp #(
   parameter int MAX_KEYS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [255:0]      req_tdata,
   input  wire logic [1:0]        req_tuser,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [231:0]           rsp_tdata,
   output logic [0:0]             rsp_tuser,
   input  wire kla_pkg::ctl_type  ctl,
   output kla_pkg::stat_type      stat
);
   import kla_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEYS);

   // latched word
   logic [1:0]  cmd_ff;
   logic [31:0] dt_ff, ktime_ff;
   pose_type    kpose_ff;

   // state
   logic             mode_ff;
   logic [31:0]      anim_ff, start_ff, end_ff, diff_ff;
   logic [CNT_W-1:0] count_ff;

   // search, divide, lerp
   logic [IDX_W-1:0]   j_ff;
   logic [31:0]        prev_ff, den_ff;
   logic [31:0]        rem_ff;
   logic [FRAC_W-1:0]  q_ff;
   logic [3:0]         dcnt_ff;
   pose_type           a_ff, b_ff, pose_ff;
   logic [2:0]         k_ff;
   logic signed [49:0] prod_ff;
   logic               pvalid_ff, ended_ff, full_ff;

   // result register
   logic        rsp_valid_ff;
   logic [231:0] rsp_data_ff;
   logic        rsp_user_ff;

   logic [31:0]  t_rdata;
   pose_type     p_rdata;
   logic [31:0]  end_t, start_t;
   logic [IDX_W-1:0] p_raddr;
   logic [32:0]  sum33, lsum33, r2;
   logic signed [32:0] dk;
   logic [31:0]  ak, bk;
   logic         wr_en;

   assign end_t   = (count_ff == '0) ? '0 : end_ff;
   assign start_t = (count_ff == '0) ? '0 : start_ff;
   assign wr_en   = ctl.do_append && (count_ff != CNT_MAX);
   assign p_raddr = ctl.pose_rd_hi ? j_ff : j_ff - IDX_W'(1);

   kla_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
      .clock (clock),
      .we    (wr_en),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (ktime_ff),
      .re    (ctl.srch_rd),
      .raddr (j_ff),
      .rdata (t_rdata)
   );

   kla_ram #(.WIDTH(NCOMP*COMP_W), .DEPTH(MAX_KEYS)) u_poses (
      .clock (clock),
      .we    (wr_en),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (kpose_ff),
      .re    (ctl.pose_rd),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   // arithmetic helpers
   assign sum33  = {1'b0, anim_ff} + {1'b0, dt_ff};
   assign lsum33 = {1'b0, start_t} + {1'b0, diff_ff};
   assign r2     = {rem_ff, 1'b0};
   assign ak     = a_ff[k_ff];
   assign bk     = b_ff[k_ff];
   assign dk     = $signed({bk[31], bk}) - $signed({ak[31], ak});

   // status
   always_comb begin
      stat           = '0;
      stat.cmd       = cmd_ff;
      stat.loop_wrap = mode_ff && (anim_ff > end_t);
      stat.cnt_lt2   = (count_ff < CNT_W'(2));
      stat.found     = (j_ff != '0) && (prev_ff < anim_ff) && (anim_ff <= t_rdata);
      stat.exact     = (anim_ff == t_rdata);
      stat.srch_last = (CNT_W'(j_ff) + CNT_W'(1)) == count_ff;
      stat.div_last  = (dcnt_ff == 4'd15);
      stat.comp_last = (k_ff == 3'(NCOMP - 1));
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign csr_ready = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         anim_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) mode_ff <= csr_data[0];
         if (wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff == '0) anim_ff <= ktime_ff;
         end
         if (ctl.do_clear) count_ff <= '0;
         if (ctl.t_add) anim_ff <= sum33[32] ? '1 : sum33[31:0];
         if (ctl.t_end && !mode_ff && (anim_ff >= end_t)) anim_ff <= end_t;
         if (ctl.t_loop) anim_ff <= lsum33[32] ? '1 : lsum33[31:0];
         if (ctl.out_load)                  rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff    <= req_tuser;
         dt_ff     <= req_tdata[31:0];
         ktime_ff  <= req_tdata[63:32];
         kpose_ff  <= req_tdata[255:64];
         j_ff      <= '0;
         pvalid_ff <= 1'b0;
         ended_ff  <= 1'b0;
         full_ff   <= 1'b0;
         pose_ff   <= '0;
      end
      // append
      if (ctl.do_append) begin
         if (count_ff == CNT_MAX) begin
            full_ff <= 1'b1;
         end else begin
            end_ff <= ktime_ff;
            if (count_ff == '0) start_ff <= ktime_ff;
         end
      end
      // end of table handling
      if (ctl.t_end) begin
         if (!mode_ff && (anim_ff >= end_t)) ended_ff <= 1'b1;
         diff_ff <= anim_ff - end_t;
      end
      // search step
      if (ctl.srch_chk) begin
         if (stat.found) begin
            pvalid_ff <= 1'b1;
            den_ff    <= t_rdata - prev_ff;
            rem_ff    <= anim_ff - prev_ff;
            q_ff      <= '0;
            dcnt_ff   <= '0;
         end else begin
            prev_ff <= t_rdata;
            j_ff    <= j_ff + IDX_W'(1);
         end
      end
      // restoring divide, one quotient bit a cycle; remainder stays below den
      if (ctl.div_step) begin
         dcnt_ff <= dcnt_ff + 4'd1;
         if (r2 >= {1'b0, den_ff}) begin
            rem_ff <= 32'(r2 - {1'b0, den_ff});
            q_ff   <= {q_ff[FRAC_W-2:0], 1'b1};
         end else begin
            rem_ff <= r2[31:0];
            q_ff   <= {q_ff[FRAC_W-2:0], 1'b0};
         end
      end
      if (ctl.set_exact) pose_ff <= p_rdata;
      if (ctl.cap_a) a_ff <= p_rdata;
      if (ctl.cap_b) begin
         b_ff <= p_rdata;
         k_ff <= '0;
      end
      // one component at a time through the shared multiplier: multiply, then accumulate
      if (ctl.mul) prod_ff <= 50'(dk) * 50'($signed({1'b0, q_ff}));
      if (ctl.acc) begin
         pose_ff[k_ff] <= ak + 32'(prod_ff >>> FRAC_W);
         k_ff          <= k_ff + 3'd1;
      end
      // result word
      if (ctl.out_load) begin
         rsp_user_ff <= pvalid_ff;
         rsp_data_ff <= {5'b0, full_ff,
                         (!mode_ff && (anim_ff == end_t)),
                         anim_ff, ended_ff, pose_ff};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

`default_nettype wire

/* rtl/keyframe_lerp_animator_top.sv */
// Append, clear and unused codes pass through execute and done before rsp_tvalid rises.
// A tick updates the time (one more state on a loop wrap), then the search scans the
// table one entry at a time; a hit on a key time reads that pose, any other hit runs the
// bit-serial fraction divide and then the six lerps through one shared multiplier.
// One word in work at a time: the next is accepted once the result is loaded; an untaken result stalls.
// Reset clears time, key count and mode; table contents stay undefined.
// ----------------------------------------------------------------------------
// keyframe_lerp_animator_top
// Keyframe table with linear pose interpolation over an animation clock.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_lerp_animator_top #(
   parameter int MAX_KEYS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // dt, key_time, key_pos_x/y/z, key_rot_x/y/z (32 each)
   input  wire logic [255:0] req_tdata,
   // cmd
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x/y/z, rot_x/y/z (32 each), ended, time_out, finished, table_full, pad
   output logic [231:0]      rsp_tdata,
   // pose_valid
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   // mode in bit 0
   input  wire logic [7:0]   csr_data
);
   import kla_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   kla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   kla_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ctl        (ctl),
      .stat       (stat)
   );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the keyframe lerp animator under several idle
// and stall patterns and compares every response word with a model of the
// keyframe table, animation clock and pose interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import kla_pkg::*;

   localparam int NKEYS   = 16;
   localparam longint CYCLE_LIMIT = 4000000;
   // code with no function
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic [1:0]   req_tuser = CMD_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [231:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   keyframe_lerp_animator_top #(.MAX_KEYS(NKEYS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // one response word as expected
   typedef struct {
      logic        pose_valid;
      logic [31:0] pose [NCOMP];
      logic        ended;
      logic [31:0] time_out;
      logic        finished;
      logic        table_full;
   } pose_word_t;

   // model state
   logic [31:0] clk_time;
   int          n_keys;
   logic [31:0] kf_time [NKEYS];
   logic [31:0] kf_pose [NKEYS][NCOMP];
   logic        loop_mode;

   pose_word_t  pending_poses [$];
   int          n_errors = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off = 0;
   longint      cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // generous limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one lerp component, product floors toward minus infinity
   function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                  logic [15:0] frac);
      logic signed [63:0] diff;
      logic signed [63:0] prod;
      diff = $signed({{32{b[31]}}, b}) - $signed({{32{a[31]}}, a});
      prod = diff * $signed({48'd0, frac});
      return a + 32'(prod >>> 16);
   endfunction

   // advance the model by one word and return the expected response
   function automatic pose_word_t animate(logic [1:0] cmd, logic [255:0] data);
      pose_word_t  w;
      logic [32:0] t;
      logic [31:0] e, s, t0, t1;
      logic [47:0] num;
      logic [15:0] frac;
      w.pose_valid = 1'b0;
      w.ended = 1'b0;
      w.table_full = 1'b0;
      for (int k = 0; k < NCOMP; k++) w.pose[k] = '0;
      e = n_keys ? kf_time[n_keys-1] : 32'd0;
      s = n_keys ? kf_time[0] : 32'd0;
      if (cmd == CMD_APPEND) begin
         if (n_keys >= NKEYS) begin
            w.table_full = 1'b1;
         end else begin
            kf_time[n_keys] = data[63:32];
            for (int k = 0; k < NCOMP; k++) kf_pose[n_keys][k] = data[64+32*k +: 32];
            n_keys++;
            if (n_keys == 1) clk_time = kf_time[0];
         end
      end else if (cmd == CMD_CLEAR) begin
         n_keys = 0;
      end else if (cmd == CMD_TICK) begin
         t = {1'b0, clk_time} + {1'b0, data[31:0]};
         if (t[32]) t = 33'hFFFFFFFF;
         if (!loop_mode) begin
            if (t >= {1'b0, e}) begin
               t = {1'b0, e};
               w.ended = 1'b1;
            end
         end else if (t > {1'b0, e}) begin
            t = {1'b0, s} + (t - {1'b0, e});
            if (t[32]) t = 33'hFFFFFFFF;
         end
         clk_time = t[31:0];
         for (int i = 0; i + 1 < n_keys; i++) begin
            t0 = kf_time[i];
            t1 = kf_time[i+1];
            if (t0 < clk_time && clk_time <= t1) begin
               w.pose_valid = 1'b1;
               if (clk_time == t1) begin
                  for (int k = 0; k < NCOMP; k++) w.pose[k] = kf_pose[i+1][k];
               end else begin
                  num = {clk_time - t0, 16'd0};
                  frac = 16'(num / {16'd0, t1 - t0});
                  for (int k = 0; k < NCOMP; k++)
                     w.pose[k] = lerp_component(kf_pose[i][k], kf_pose[i+1][k], frac);
               end
               break;
            end
         end
      end
      e = n_keys ? kf_time[n_keys-1] : 32'd0;
      w.time_out = clk_time;
      w.finished = !loop_mode && clk_time == e;
      return w;
   endfunction

   // response checker
   always @(posedge clock) begin
      pose_word_t w;
      logic       bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_poses.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("response word with nothing expected");
         end else begin
            w = pending_poses.pop_front();
            bad = rsp_tuser[0] !== w.pose_valid || rsp_tdata[192] !== w.ended ||
                  rsp_tdata[224:193] !== w.time_out || rsp_tdata[225] !== w.finished ||
                  rsp_tdata[226] !== w.table_full;
            for (int k = 0; k < NCOMP; k++)
               if (rsp_tdata[32*k +: 32] !== w.pose[k]) bad = 1'b1;
            if (bad) begin
               n_errors++;
               if (n_errors <= 10)
                  $display({"mismatch: exp valid %b pose %h %h %h %h %h %h",
                            " end %b t %h fin %b full %b"},
                           w.pose_valid, w.pose[0], w.pose[1], w.pose[2], w.pose[3],
                           w.pose[4], w.pose[5], w.ended, w.time_out, w.finished,
                           w.table_full, "\n          got valid %b data %h",
                           rsp_tuser[0], rsp_tdata);
            end
         end
      end
   end

   // receiver stalls, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // valid stays up between back-to-back words and drops in idle cycles
   task automatic send_word(logic [1:0] cmd, logic [255:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      pending_poses.insert(pending_poses.size(), animate(cmd, data));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_mode(logic [7:0] value);
      drain();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      loop_mode = value[0];
   endtask

   function automatic logic [255:0] key_data(logic [31:0] kt);
      logic [255:0] d;
      for (int k = 0; k < 8; k++) d[32*k +: 32] = $urandom;
      d[63:32] = kt;
      return d;
   endfunction

   task automatic send_tick(logic [31:0] dt);
      logic [255:0] d;
      d = key_data($urandom);
      d[31:0] = dt;
      send_word(CMD_TICK, d);
   endtask

   // directed corners: empty table, extremes, full table, exact keys, unused code
   task automatic test_directed;
      logic [255:0] d;
      send_tick(32'd5);
      send_word(CMD_CLEAR, key_data(0));
      send_word(CMD_UNUSED, '1);
      d = '0; d[63:32] = 32'd0;
      for (int k = 2; k < 8; k++) d[32*k +: 32] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      send_word(CMD_APPEND, d);
      d[63:32] = 32'hFFFF_FFFF;
      for (int k = 2; k < 8; k++) d[32*k +: 32] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      send_word(CMD_APPEND, d);
      send_tick(32'h8000_0000);
      send_tick(32'd1);
      send_tick(32'hFFFF_FFFF);
      send_word(CMD_CLEAR, key_data(0));
      for (int i = 0; i < NKEYS + 2; i++) send_word(CMD_APPEND, key_data(32'(i) << 16));
      send_tick(32'h0001_0000);
      send_tick(32'h0000_8000);
   endtask

   // random sessions: fill a table with mostly ascending key times, then send mostly ticks
   task automatic test_random(int n_words, int idle, int stall);
      int          sent;
      logic [31:0] kt;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      sent = 0;
      while (sent < n_words) begin
         send_word(CMD_CLEAR, key_data($urandom));
         sent++;
         kt = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000);
         for (int i = $urandom_range(NKEYS + 1); i > 0; i--) begin
            send_word(CMD_APPEND, key_data(kt));
            sent++;
            kt = $urandom_range(9) == 0 ? $urandom : kt + $urandom_range(32'h30000);
         end
         for (int i = $urandom_range(12); i > 0; i--) begin
            case ($urandom_range(9))
               0: send_tick($urandom);
               1: send_word(2'($urandom_range(3)), key_data($urandom));
               2: send_tick('0);
               default: send_tick($urandom_range(32'h20000));
            endcase
            sent++;
         end
      end
   endtask

   // long receiver hold-off while words keep coming
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 400;
      for (int i = 0; i < 20; i++) send_tick($urandom_range(32'h10000));
   endtask

   initial begin
      clk_time = '0;
      n_keys = 0;
      loop_mode = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_mode(8'hFF);
      test_directed();
      test_random(500, 0, 0);
      write_mode(8'h00);
      test_random(500, 72, 0);
      test_backpressure();
      write_mode(8'h01);
      test_random(500, 0, 72);
      write_mode(8'hFE);
      test_random(350, 10, 10);
      drain();
      if (n_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/kla_pkg.sv
rtl/kla_ram.sv
rtl/kla_ctrl.sv
rtl/kla_dp.sv
rtl/keyframe_lerp_animator_top.sv
dv/testbench.sv
